>>> hw/rtl/mzs_pkg.sv
package mzs_pkg;

   // default geometry of the element store
   localparam int MZS_MAX_ROWS    = 16;
   localparam int MZS_MAX_COLUMNS = 16;
   localparam int MZS_DATA_WIDTH  = 32;

   // fixed field widths on the ports
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int CFG_W       = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = 5'd8;
   localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 5'd8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 2'd1;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

endpackage

>>> hw/rtl/mzs_if.sv
interface mzs_req_if;
   import mzs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [VALUE_W-1:0] element_value;

   modport source (output valid, output opcode, output element_value, input ready);
   modport sink   (input valid, input opcode, input element_value, output ready);
endinterface

interface mzs_rsp_if;
   import mzs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic [INDEX_W-1:0]        row_index;
   logic [INDEX_W-1:0]        column_index;
   logic                      last;

   modport source (output valid, output read_value, output row_index, output column_index,
                   output last, input ready);
   modport sink   (input valid, input read_value, input row_index, input column_index,
                   input last, output ready);
endinterface

interface mzs_csr_if;
   import mzs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/mzs_fifo.sv
module mzs_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int QD = 2;

   logic [WIDTH-1:0]   entries_ff [QD];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != 2'(QD));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QD))
      else $error("queue fill beyond depth");

   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue fill did not rise on push");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue fill did not fall on pop");

   a_ptrs_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(QD)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step with fill");
`endif
endmodule

>>> hw/rtl/mzs_front.sv
module mzs_front #(
   parameter int MAX_ROWS    = mzs_pkg::MZS_MAX_ROWS,
   parameter int MAX_COLUMNS = mzs_pkg::MZS_MAX_COLUMNS,
   parameter int DATA_WIDTH  = mzs_pkg::MZS_DATA_WIDTH,
   parameter int ENTRY_W     = 8
) (
   input  logic               clock,
   input  logic               reset,
   mzs_req_if.sink            req_bus,
   mzs_csr_if.sink            csr_bus,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_entry
);
   import mzs_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   typedef struct packed {
      logic                  is_read;
      logic [AW-1:0]         addr;
      logic [INDEX_W-1:0]    row;
      logic [INDEX_W-1:0]    column;
      logic                  last;
      logic [DATA_WIDTH-1:0] data;
   } entry_type;

   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [CFG_W-1:0] column_count_ff, column_count_in;
   logic [RW-1:0]    wr_row_ff, wr_row_in;
   logic [CW-1:0]    wr_col_ff, wr_col_in;
   logic [RW-1:0]    scan_row_ff, scan_row_in;
   logic [CW-1:0]    scan_col_ff, scan_col_in;
   logic             moving_up_ff, moving_up_in;

   logic [RW-1:0]    row_last;
   logic [CW-1:0]    col_last;
   logic             item_accept, csr_accept, is_read;
   logic             row_end, col_end, scan_last;
   logic [RW-1:0]    addr_row;
   logic [CW-1:0]    addr_col;
   entry_type        entry;

   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;
   assign push_valid    = req_bus.valid;
   assign item_accept   = req_bus.valid && push_ready;
   assign csr_accept    = csr_bus.valid;
   assign is_read       = (req_bus.opcode == OP_READ);

   // last row / column in use, sizes clamped to 1..MAX
   always_comb begin
      if (row_count_ff == '0) begin
         row_last = '0;
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         row_last = RW'(MAX_ROWS - 1);
      end else begin
         row_last = RW'(row_count_ff - CFG_W'(1));
      end
      if (column_count_ff == '0) begin
         col_last = '0;
      end else if (int'(column_count_ff) > MAX_COLUMNS) begin
         col_last = CW'(MAX_COLUMNS - 1);
      end else begin
         col_last = CW'(column_count_ff - CFG_W'(1));
      end
   end

   assign row_end   = (scan_row_ff == row_last);
   assign col_end   = (scan_col_ff == col_last);
   // zigzag always ends in the bottom right corner
   assign scan_last = row_end && col_end;

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      wr_row_in       = wr_row_ff;
      wr_col_in       = wr_col_ff;
      scan_row_in     = scan_row_ff;
      scan_col_in     = scan_col_ff;
      moving_up_in    = moving_up_ff;
      if (csr_accept) begin
         if (csr_bus.index == CSR_ROW_COUNT) begin
            row_count_in = csr_bus.data;
         end else if (csr_bus.index == CSR_COLUMN_COUNT) begin
            column_count_in = csr_bus.data;
         end
         if (csr_bus.index == CSR_ROW_COUNT || csr_bus.index == CSR_COLUMN_COUNT) begin
            wr_row_in    = '0;
            wr_col_in    = '0;
            scan_row_in  = '0;
            scan_col_in  = '0;
            moving_up_in = 1'b1;
         end
      end else if (item_accept && !is_read) begin
         if (wr_col_ff != col_last) begin
            wr_col_in = wr_col_ff + CW'(1);
         end else begin
            wr_col_in = '0;
            wr_row_in = (wr_row_ff != row_last) ? wr_row_ff + RW'(1) : '0;
         end
      end else if (item_accept) begin
         if (scan_last) begin
            scan_row_in  = '0;
            scan_col_in  = '0;
            moving_up_in = 1'b1;
         end else if (moving_up_ff) begin
            if (scan_row_ff != '0 && !col_end) begin
               scan_row_in = scan_row_ff - RW'(1);
               scan_col_in = scan_col_ff + CW'(1);
            end else begin
               if (!col_end) begin
                  scan_col_in = scan_col_ff + CW'(1);
               end else begin
                  scan_row_in = scan_row_ff + RW'(1);
               end
               moving_up_in = 1'b0;
            end
         end else begin
            if (!row_end && scan_col_ff != '0) begin
               scan_row_in = scan_row_ff + RW'(1);
               scan_col_in = scan_col_ff - CW'(1);
            end else begin
               if (!row_end) begin
                  scan_row_in = scan_row_ff + RW'(1);
               end else begin
                  scan_col_in = scan_col_ff + CW'(1);
               end
               moving_up_in = 1'b1;
            end
         end
      end
   end

   assign addr_row = is_read ? scan_row_ff : wr_row_ff;
   assign addr_col = is_read ? scan_col_ff : wr_col_ff;

   always_comb begin
      entry.is_read = is_read;
      entry.addr    = AW'(int'(addr_row) * MAX_COLUMNS + int'(addr_col));
      entry.row     = INDEX_W'(scan_row_ff);
      entry.column  = INDEX_W'(scan_col_ff);
      entry.last    = scan_last;
      entry.data    = DATA_WIDTH'($unsigned(req_bus.element_value));
   end

   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
         wr_row_ff       <= '0;
         wr_col_ff       <= '0;
         scan_row_ff     <= '0;
         scan_col_ff     <= '0;
         moving_up_ff    <= 1'b1;
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         wr_row_ff       <= wr_row_in;
         wr_col_ff       <= wr_col_in;
         scan_row_ff     <= scan_row_in;
         scan_col_ff     <= scan_col_in;
         moving_up_ff    <= moving_up_in;
      end
   end
endmodule

>>> hw/rtl/mzs_back.sv
module mzs_back #(
   parameter int MAX_ROWS    = mzs_pkg::MZS_MAX_ROWS,
   parameter int MAX_COLUMNS = mzs_pkg::MZS_MAX_COLUMNS,
   parameter int DATA_WIDTH  = mzs_pkg::MZS_DATA_WIDTH,
   parameter int ENTRY_W     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_entry,
   mzs_rsp_if.source          rsp_bus
);
   import mzs_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef struct packed {
      logic                  is_read;
      logic [AW-1:0]         addr;
      logic [INDEX_W-1:0]    row;
      logic [INDEX_W-1:0]    column;
      logic                  last;
      logic [DATA_WIDTH-1:0] data;
   } entry_type;

   logic [DATA_WIDTH-1:0] element_store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [INDEX_W-1:0]    row_ff;
   logic [INDEX_W-1:0]    column_ff;
   logic                  last_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   entry_type             entry;
   logic                  out_free, pop;

   assign entry     = pop_entry;
   // output register free, or its beat leaves this cycle
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pop_ready = !entry.is_read || out_free;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && entry.is_read) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !entry.is_read) begin
         element_store_ff[entry.addr] <= entry.data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && entry.is_read) begin
         rd_data_ff <= element_store_ff[entry.addr];
         row_ff     <= entry.row;
         column_ff  <= entry.column;
         last_ff    <= entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.read_value   = $signed(VALUE_W'(rd_data_ff));
   assign rsp_bus.row_index    = row_ff;
   assign rsp_bus.column_index = column_ff;
   assign rsp_bus.last         = last_ff;

`ifndef SYNTH
   a_read_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (pop && entry.is_read) |=> rsp_valid_ff)
      else $error("read popped without a result beat");

   a_write_no_beat: assert property (@(posedge clock) disable iff (reset)
      (pop && !entry.is_read && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("write produced a result beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pop && entry.is_read) |-> out_free)
      else $error("read popped over a pending result");
`endif
endmodule

>>> hw/rtl/matrix_zigzag_scan_core.sv
// A read beat passes the queue and then the result register before it is offered on rsp_bus.
// Throughput: one beat per cycle, reads and writes alike, while rsp_bus keeps up; the
//   single port of the element store handles one beat each cycle from a 2-entry queue.
// Reset: sizes go to 8 x 8, write and scan positions to the origin, scan direction
//   up and right, queue and result register empty. Element store contents are
//   undefined until written; there is no clearing pass.
module matrix_zigzag_scan_core #(
   parameter int MAX_ROWS    = mzs_pkg::MZS_MAX_ROWS,
   parameter int MAX_COLUMNS = mzs_pkg::MZS_MAX_COLUMNS,
   parameter int DATA_WIDTH  = mzs_pkg::MZS_DATA_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   mzs_req_if.sink    req_bus,
   mzs_rsp_if.source  rsp_bus,
   mzs_csr_if.sink    csr_bus
);
   import mzs_pkg::*;

   // store address covers MAX_ROWS x MAX_COLUMNS, entry = row * MAX_COLUMNS + column
   localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // queue beat: op flag, address, row, column, last flag, write data
   localparam int ENTRY_W = 1 + AW + 2 * INDEX_W + 1 + DATA_WIDTH;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_entry;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_entry;

   // Front: takes req beats and csr writes, owns the size registers and
   // the write and zigzag positions, turns each beat into a store access.
   mzs_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .DATA_WIDTH  (DATA_WIDTH),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Short queue so a stalled rsp side does not stop req acceptance at once.
   mzs_fifo #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_entry)
   );

   // Back: element store and result register. Writes retire on pop; reads
   // wait for the result register to be free.
   mzs_back #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .DATA_WIDTH  (DATA_WIDTH),
      .ENTRY_W     (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );
endmodule

>>> verif/matrix_zigzag_scan_core_tb.sv
`timescale 1ns / 100ps

module matrix_zigzag_scan_core_tb;
   import mzs_pkg::*;

   // run sizing
   localparam int RANDOM_ITEMS    = 900;
   localparam int DRAIN_CYCLES    = 4;      // writes leave no result
   localparam int HOLD_OFF_CYCLES = 300;    // long receiver hold-off for the fill-up test
   localparam int CYCLE_LIMIT     = 300000;
   localparam int STORE_SLOTS     = MZS_MAX_ROWS * MZS_MAX_COLUMNS;

   // indexes the block decodes as no register at all
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // receiver pacing
   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_COIN,
      RSP_EVERY_THIRD,
      RSP_MOSTLY
   } rsp_pace_type;

   // one expected read beat
   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        column_index;
      logic                      last;
   } scan_beat_type;

   logic clock;
   logic reset;

   mzs_req_if req_bus ();
   mzs_rsp_if rsp_bus ();
   mzs_csr_if csr_bus ();

   matrix_zigzag_scan_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------
   // Shadow of the block: sizes, element store and the two walkers
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0]          row_count_q    = ROW_COUNT_RESET;
   logic [CFG_W-1:0]          column_count_q = COLUMN_COUNT_RESET;
   logic signed [VALUE_W-1:0] element_mem [0:STORE_SLOTS-1];
   bit                        element_written [0:STORE_SLOTS-1];
   logic [INDEX_W-1:0]        wr_row   = '0;
   logic [INDEX_W-1:0]        wr_col   = '0;
   logic [INDEX_W-1:0]        sc_row   = '0;
   logic [INDEX_W-1:0]        sc_col   = '0;
   logic                      sc_up    = 1'b1;
   logic [8:0]                sc_count = '0;

   scan_beat_type zigzag_due [$];    // read beats still to come out of rsp_bus

   int           error_count  = 0;
   int           cycle_count  = 0;
   int           random_beats = 0;
   int           burst_left   = 0;
   bit           gaps_enabled = 1'b0;
   bit           req_held     = 1'b0;  // req valid still high after the last accepted beat
   bit           hold_off_req = 1'b0;
   rsp_pace_type rsp_mode     = RSP_ALWAYS;

   // ---------------------------------------------------------------------
   // Clock and cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("matrix_zigzag_scan_core: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // out-of-range sizes: zero acts as one, anything above the store acts as the maximum
   function automatic int eff_size(logic [CFG_W-1:0] raw, int limit);
      if (raw == 0)
         return 1;
      if (raw > limit)
         return limit;
      return int'(raw);
   endfunction

   // any size write sends both walkers home; stored data survives
   task automatic restart_positions();
      wr_row   = '0;
      wr_col   = '0;
      sc_row   = '0;
      sc_col   = '0;
      sc_up    = 1'b1;
      sc_count = '0;
   endtask

   task automatic predict_zigzag_item(op_type op, logic signed [VALUE_W-1:0] value);
      int            rows;
      int            cols;
      int            slot;
      scan_beat_type beat;
      rows = eff_size(row_count_q, MZS_MAX_ROWS);
      cols = eff_size(column_count_q, MZS_MAX_COLUMNS);
      if (op == OP_WRITE) begin
         // raster order, wrapping to the origin after the last element
         slot = wr_row * MZS_MAX_COLUMNS + wr_col;
         element_mem[slot]     = value;
         element_written[slot] = 1'b1;
         if (wr_col + 1 < cols) begin
            wr_col++;
         end else begin
            wr_col = '0;
            wr_row = (wr_row + 1 < rows) ? wr_row + 1'b1 : '0;
         end
      end else begin
         slot              = sc_row * MZS_MAX_COLUMNS + sc_col;
         beat.read_value   = element_mem[slot];
         beat.row_index    = sc_row;
         beat.column_index = sc_col;
         beat.last         = (sc_count + 1 >= rows * cols);
         zigzag_due        = {zigzag_due, beat};
         if (beat.last) begin
            sc_row   = '0;
            sc_col   = '0;
            sc_up    = 1'b1;
            sc_count = '0;
         end else begin
            if (sc_up) begin
               // up-right, else step right (down at the corner) and turn
               if (sc_row > 0 && sc_col + 1 < cols) begin
                  sc_row--;
                  sc_col++;
               end else begin
                  if (sc_col + 1 < cols)
                     sc_col++;
                  else
                     sc_row++;
                  sc_up = 1'b0;
               end
            end else begin
               // down-left, else step down (right at the corner) and turn
               if (sc_row + 1 < rows && sc_col > 0) begin
                  sc_row++;
                  sc_col--;
               end else begin
                  if (sc_row + 1 < rows)
                     sc_row++;
                  else
                     sc_col++;
                  sc_up = 1'b1;
               end
            end
            sc_count++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CFG_W'($urandom_range(16, 31));
         default: return CFG_W'($urandom_range(1, 6));
      endcase
   endfunction

   // lower req valid once, in the step of the last accepted beat
   task automatic drop_req();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // one beat on req_bus; valid stays up so that a burst runs back to back
   task automatic send_item(op_type op, logic signed [VALUE_W-1:0] value);
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= op;
      req_bus.element_value <= value;
      req_held = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      predict_zigzag_item(op, value);
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            drop_req();
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // a read that would land on a never-written entry turns into a write
   task automatic send_random_item(op_type op);
      if (op == OP_READ && !element_written[sc_row * MZS_MAX_COLUMNS + sc_col])
         op = OP_WRITE;
      send_item(op, pick_value());
      random_beats++;
   endtask

   // registers only change with the block drained
   task automatic write_csr(logic [CSR_INDEX_W-1:0] reg_index, logic [CFG_W-1:0] data);
      drop_req();
      while (zigzag_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= data;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (reg_index)
         CSR_ROW_COUNT: begin
            row_count_q = data;
            restart_positions();
         end
         CSR_COLUMN_COUNT: begin
            column_count_q = data;
            restart_positions();
         end
         default: ;  // spare index: nothing moves
      endcase
   endtask

   task automatic report_mismatch(string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Receiver: own stall pattern, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int hold_cycles;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
               @(posedge clock);
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else begin
            case (rsp_mode)
               RSP_ALWAYS:      rsp_bus.ready <= 1'b1;
               RSP_COIN:        rsp_bus.ready <= 1'($urandom_range(0, 1));
               RSP_EVERY_THIRD: rsp_bus.ready <= (cycle_count % 3 == 0);
               default:         rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result check: every accepted rsp beat against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      scan_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (zigzag_due.size() == 0) begin
            report_mismatch("rsp beat with nothing expected");
         end else begin
            want = zigzag_due.pop_front();
            if (rsp_bus.read_value !== want.read_value)
               report_mismatch($sformatf("read_value got %0d want %0d",
                                         rsp_bus.read_value, want.read_value));
            if (rsp_bus.row_index !== want.row_index)
               report_mismatch($sformatf("row_index got %0d want %0d",
                                         rsp_bus.row_index, want.row_index));
            if (rsp_bus.column_index !== want.column_index)
               report_mismatch($sformatf("column_index got %0d want %0d",
                                         rsp_bus.column_index, want.column_index));
            if (rsp_bus.last !== want.last)
               report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                         rsp_bus.last, want.last,
                                         want.row_index, want.column_index));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // 8 x 8 out of reset: nine writes reach (1,0), the first three scan steps use them
   task automatic test_reset_geometry();
      int k;
      gaps_enabled = 1'b0;
      rsp_mode     = RSP_ALWAYS;
      for (k = 0; k < 9; k++)
         send_item(OP_WRITE, pick_value());
      for (k = 0; k < 3; k++)
         send_item(OP_READ, pick_value());
   endtask

   // both sizes written as zero give a 1 x 1 matrix; every read is the last
   task automatic test_single_element();
      write_csr(CSR_ROW_COUNT, 5'd0);
      write_csr(CSR_COLUMN_COUNT, 5'd0);
      send_item(OP_WRITE, 32'sh8000_0000);
      send_item(OP_READ, 32'sh7FFF_FFFF);   // payload of a read is ignored
      send_item(OP_READ, '0);
   endtask

   // a size write mid-scan sends write and scan positions back to the origin
   task automatic test_size_change_restart();
      int k;
      write_csr(CSR_ROW_COUNT, 5'd2);
      write_csr(CSR_COLUMN_COUNT, 5'd2);
      send_item(OP_WRITE, 32'sh7FFF_FFFF);
      send_item(OP_WRITE, '0);
      send_item(OP_WRITE, '1);
      send_item(OP_WRITE, 32'sh8000_0000);
      send_item(OP_READ, '1);
      send_item(OP_READ, '0);
      write_csr(CSR_COLUMN_COUNT, 5'd2);
      send_item(OP_WRITE, 32'sh1234_5678);   // lands on (0,0) again
      for (k = 0; k < 4; k++)
         send_item(OP_READ, pick_value());
   endtask

   // writes to the spare indexes leave the scan where it was
   task automatic test_spare_registers();
      send_item(OP_READ, '0);
      write_csr(CSR_SPARE_A, 5'd31);
      write_csr(CSR_SPARE_B, 5'd0);
      send_item(OP_READ, '1);
   endtask

   // receiver holds off for a long stretch while reads keep coming: input must stall
   task automatic test_input_stall();
      int k;
      write_csr(CSR_ROW_COUNT, 5'd4);
      write_csr(CSR_COLUMN_COUNT, 5'd4);
      gaps_enabled = 1'b0;
      rsp_mode     = RSP_ALWAYS;
      for (k = 0; k < 16; k++)
         send_item(OP_WRITE, pick_value());
      hold_off_req = 1'b1;
      for (k = 0; k < 40; k++)
         send_item(OP_READ, pick_value());
   endtask

   // phases of random geometry; mostly a full fill then scans, sometimes mixed noise
   task automatic test_random_phases();
      logic [CFG_W-1:0] raw_rows;
      logic [CFG_W-1:0] raw_cols;
      int               phase;
      int               total;
      int               reads;
      int               k;
      phase = 0;
      while (random_beats < RANDOM_ITEMS) begin
         case (phase)
            0:       begin raw_rows = 5'd3;  raw_cols = 5'd5;  end
            1:       begin raw_rows = 5'd0;  raw_cols = 5'd31; end
            2:       begin raw_rows = 5'd31; raw_cols = 5'd0;  end
            3:       begin raw_rows = 5'd16; raw_cols = 5'd16; end
            4:       begin raw_rows = 5'd1;  raw_cols = 5'd1;  end
            5:       begin raw_rows = 5'd17; raw_cols = 5'd2;  end
            default: begin raw_rows = pick_size(); raw_cols = pick_size(); end
         endcase
         gaps_enabled = ($urandom_range(0, 3) != 0);
         rsp_mode     = rsp_pace_type'($urandom_range(0, 3));
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_ROW_COUNT, raw_rows);
            write_csr(CSR_COLUMN_COUNT, raw_cols);
         end else begin
            write_csr(CSR_COLUMN_COUNT, raw_cols);
            write_csr(CSR_ROW_COUNT, raw_rows);
         end
         total = eff_size(raw_rows, MZS_MAX_ROWS) * eff_size(raw_cols, MZS_MAX_COLUMNS);
         if (phase == 3 || $urandom_range(0, 9) < 7) begin
            for (k = 0; k < total; k++)
               send_random_item(OP_WRITE);
            // beyond 64 elements, as in the full 16 x 16 case, the scan runs once only
            reads = (total > 64) ? total
                                 : total * $urandom_range(1, 3) + $urandom_range(0, total - 1);
            for (k = 0; k < reads; k++)
               send_random_item(($urandom_range(0, 9) == 0) ? OP_WRITE : OP_READ);
         end else begin
            for (k = 0; k < 2 * total + 4; k++)
               send_random_item(op_type'($urandom_range(0, 1)));
         end
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.opcode        <= OP_WRITE;
      req_bus.element_value <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_ROW_COUNT;
      csr_bus.data          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_single_element();
      test_size_change_restart();
      test_spare_registers();
      test_input_stall();
      test_random_phases();

      // drain: every expected beat out, then quiet cycles to catch strays
      drop_req();
      rsp_mode = RSP_MOSTLY;
      while (zigzag_due.size() != 0)
         @(posedge clock);
      repeat (4 * DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && zigzag_due.size() == 0)
         $display("matrix_zigzag_scan_core: match");
      else
         $display("matrix_zigzag_scan_core: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mzs_pkg.sv
hw/rtl/mzs_if.sv
hw/rtl/mzs_fifo.sv
hw/rtl/mzs_front.sv
hw/rtl/mzs_back.sv
hw/rtl/matrix_zigzag_scan_core.sv
verif/matrix_zigzag_scan_core_tb.sv
